// File: sv/unrt_pkg.sv
`timescale 1ns / 1ps
package unrt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int NAME_CHARS_DEF = 16;
  localparam int BASE_CHARS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int SFX_DIGITS     = 3;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_LOOKUP   = 2'd1;
  localparam logic [1:0] CMD_OWNER    = 2'd2;
  localparam logic [1:0] CMD_RELEASE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [3:0] DEC_MAX   = 4'd9;

endpackage

// File: sv/unique_name_registry_table_core.sv
`timescale 1ns / 1ps
// Unique name registry table.
// Input channel (in_*): one item per transfer. Register (cmd 0) and lookup
// (cmd 1) send a name one byte per item; the item with in_name_last set runs
// the operation. Owner query (cmd 2) and release (cmd 3) run on any item.
// Result channel (out_*): one or more transfers per operation, out_last on
// the final one. A successful register or owner query streams the name one
// byte per transfer; every other result is a single transfer.
// The front accepts one item per cycle while the two-entry operation queue
// has room. The back runs one operation at a time, reading and then
// comparing each slot visited in the table scan. Register first scans for
// a free slot, then builds a candidate and scans the table for each tried
// suffix, up to SLOTS+1 suffixes, and then streams the name one byte per
// transfer.
// Reset clears every valid mark, the partial name's length and the queue.
// A stalled receiver holds the output register; the back waits on it and,
// once the queue fills, in_ready drops.
module unique_name_registry_table_core import unrt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int NAME_CHARS = NAME_CHARS_DEF,
  parameter int BASE_CHARS = BASE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_name_char,
  input  logic        in_name_last,
  input  logic [31:0] in_owner_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_id,
  output logic [7:0]  out_char,
  output logic        out_last
);

  localparam int LEN_W = $clog2(NAME_CHARS);
  localparam int OP_W = 2 + LEN_W + 32 + (NAME_CHARS - 1) * 8;

  logic            q_full, q_push, q_valid, q_pop;
  logic [OP_W-1:0] q_wdata, q_rdata;

  unrt_front #(.NAME_CHARS(NAME_CHARS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_name_char, .in_name_last,
    .in_owner_id, .q_full, .q_push, .q_data(q_wdata)
  );

  unrt_queue #(.W(OP_W)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rvalid(q_valid), .rdata(q_rdata)
  );

  unrt_back #(.SLOTS(SLOTS), .NAME_CHARS(NAME_CHARS), .BASE_CHARS(BASE_CHARS)) u_back (
    .clk, .rst_n, .q_valid, .q_data(q_rdata), .q_pop, .out_valid, .out_ready,
    .out_status, .out_found_id, .out_char, .out_last
  );

endmodule

// File: sv/unrt_front.sv
`timescale 1ns / 1ps
module unrt_front import unrt_pkg::*; #(
  parameter int NAME_CHARS = NAME_CHARS_DEF,
  localparam int NAME_LIMIT = NAME_CHARS - 1,
  localparam int NAME_W = NAME_LIMIT * 8,
  localparam int LEN_W = $clog2(NAME_CHARS),
  localparam int OP_W = 2 + LEN_W + 32 + NAME_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  logic [7:0]      in_name_char,
  input  logic            in_name_last,
  input  logic [31:0]     in_owner_id,
  input  logic            q_full,
  output logic            q_push,
  output logic [OP_W-1:0] q_data
);

  logic [NAME_W-1:0] name_r, name_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              end_r, end_nxt;
  logic              xfer;
  logic              is_name;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;
  assign is_name  = (in_cmd == CMD_REGISTER) || (in_cmd == CMD_LOOKUP);

  always_comb begin
    name_nxt = name_r;
    len_nxt  = len_r;
    end_nxt  = end_r;
    if (!end_r) begin
      if (in_name_char == 8'h00) begin
        end_nxt = 1'b1;
      end else if (int'(len_r) < NAME_LIMIT) begin
        for (int i = 0; i < NAME_LIMIT; i++) begin
          if (int'(len_r) == i) name_nxt[i*8 +: 8] = in_name_char;
        end
        len_nxt = len_r + LEN_W'(1);
      end
    end
  end

  assign q_push = xfer && (!is_name || in_name_last);
  assign q_data = {in_cmd, len_nxt, in_owner_id, name_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      end_r <= 1'b0;
    end else if (xfer && is_name) begin
      name_r <= name_nxt;
      if (in_name_last) begin
        len_r <= '0;
        end_r <= 1'b0;
      end else begin
        len_r <= len_nxt;
        end_r <= end_nxt;
      end
    end
  end

endmodule

// File: sv/unrt_queue.sv
`timescale 1ns / 1ps
module unrt_queue import unrt_pkg::*; #(
  parameter int W = 8,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         rvalid,
  output logic [W-1:0] rdata
);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (int'(wr_r) == QUEUE_DEPTH - 1) ? '0 : wr_r + PTR_W'(1);
      if (pop)  rd_r <= (int'(rd_r) == QUEUE_DEPTH - 1) ? '0 : rd_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

// File: sv/unrt_back.sv
`timescale 1ns / 1ps
module unrt_back import unrt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int NAME_CHARS = NAME_CHARS_DEF,
  parameter int BASE_CHARS = BASE_CHARS_DEF,
  localparam int NAME_LIMIT = NAME_CHARS - 1,
  localparam int NAME_W = NAME_LIMIT * 8,
  localparam int LEN_W = $clog2(NAME_CHARS),
  localparam int OP_W = 2 + LEN_W + 32 + NAME_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  logic [OP_W-1:0] q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [31:0]     out_found_id,
  output logic [7:0]      out_char,
  output logic            out_last
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCNT_W = $clog2(SLOTS + 1);
  localparam int ROW_W = 32 + LEN_W + NAME_W;
  localparam int BASE_LIMIT = BASE_CHARS - 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FREE, S_BUILD, S_READ, S_CMP, S_WRITE, S_STREAM, S_REPLY
  } state_t;

  state_t            state_r;
  logic [1:0]        cmd_r;
  logic [LEN_W-1:0]  len_r;
  logic [31:0]       id_r;
  logic [NAME_W-1:0] name_r;
  logic [SCNT_W-1:0] scan_r;
  logic [SLOT_W-1:0] free_r;
  logic [3:0]        bcd_r [SFX_DIGITS];
  logic [SCNT_W-1:0] try_r;
  logic [NAME_W-1:0] cand_r, cand_nxt;
  logic [LEN_W-1:0]  clen_r, clen_nxt;
  logic [LEN_W-1:0]  idx_r;
  logic [SLOTS-1:0]  valid_r;
  logic [1:0]        rep_status_r;
  logic [31:0]       rep_id_r;
  logic [ROW_W-1:0]  mem [SLOTS];
  logic [ROW_W-1:0]  rdata_r;
  logic              out_valid_r, out_last_r;
  logic [1:0]        out_status_r;
  logic [31:0]       out_id_r;
  logic [7:0]        out_char_r;

  logic [1:0]        q_cmd;
  logic [LEN_W-1:0]  q_len, q_blen;
  logic [31:0]       q_id;
  logic [NAME_W-1:0] q_name;
  logic [SLOT_W-1:0] sidx;
  logic              last_slot;
  logic [31:0]       row_owner;
  logic [LEN_W-1:0]  row_len;
  logic [NAME_W-1:0] row_name;
  logic              name_eq, hit, can_load, mem_we;
  logic [1:0]        nd;
  logic [3:0]        sfx [SFX_DIGITS];

  assign q_cmd  = q_data[OP_W-1 -: 2];
  assign q_len  = q_data[NAME_W+32 +: LEN_W];
  assign q_id   = q_data[NAME_W +: 32];
  assign q_name = q_data[NAME_W-1:0];
  assign q_blen = (int'(q_len) < BASE_LIMIT) ? q_len : LEN_W'(BASE_LIMIT);

  assign sidx      = scan_r[SLOT_W-1:0];
  assign last_slot = (sidx == SLOT_W'(SLOTS - 1));
  assign row_owner = rdata_r[ROW_W-1 -: 32];
  assign row_len   = rdata_r[NAME_W +: LEN_W];
  assign row_name  = rdata_r[NAME_W-1:0];
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign can_load  = !out_valid_r || out_ready;
  assign mem_we    = (state_r == S_WRITE);

  always_comb begin
    nd = 2'd1;
    if (bcd_r[2] != 4'd0)      nd = 2'd3;
    else if (bcd_r[1] != 4'd0) nd = 2'd2;
    sfx[0] = bcd_r[0];
    sfx[1] = 4'd0;
    sfx[2] = 4'd0;
    unique case (nd)
      2'd3: begin
        sfx[0] = bcd_r[2];
        sfx[1] = bcd_r[1];
        sfx[2] = bcd_r[0];
      end
      2'd2: begin
        sfx[0] = bcd_r[1];
        sfx[1] = bcd_r[0];
      end
      default: sfx[0] = bcd_r[0];
    endcase
    for (int i = 0; i < NAME_LIMIT; i++) begin
      if (i < int'(len_r)) begin
        cand_nxt[i*8 +: 8] = name_r[i*8 +: 8];
      end else if (i - int'(len_r) < int'(nd)) begin
        cand_nxt[i*8 +: 8] = CHAR_ZERO + {4'd0, sfx[2'(i - int'(len_r))]};
      end else begin
        cand_nxt[i*8 +: 8] = 8'h00;
      end
    end
    if (int'(len_r) + int'(nd) < NAME_LIMIT) clen_nxt = LEN_W'(int'(len_r) + int'(nd));
    else clen_nxt = LEN_W'(NAME_LIMIT);
  end

  always_comb begin
    name_eq = (row_len == clen_r);
    for (int i = 0; i < NAME_LIMIT; i++) begin
      if (i < int'(clen_r) && row_name[i*8 +: 8] != cand_r[i*8 +: 8]) name_eq = 1'b0;
    end
    if (cmd_r == CMD_OWNER || cmd_r == CMD_RELEASE) hit = valid_r[sidx] && (row_owner == id_r);
    else hit = valid_r[sidx] && name_eq;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[free_r] <= {id_r, clen_r, cand_r};
    rdata_r <= mem[sidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !(can_load && (state_r == S_STREAM || state_r == S_REPLY)))
        out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r  <= q_cmd;
            id_r   <= q_id;
            name_r <= q_name;
            scan_r <= '0;
            len_r  <= (q_cmd == CMD_REGISTER) ? q_blen : q_len;
            cand_r <= q_name;
            clen_r <= q_len;
            if (q_cmd == CMD_REGISTER) begin
              if (q_blen == '0) begin
                rep_status_r <= ST_EMPTY;
                rep_id_r     <= '0;
                state_r      <= S_REPLY;
              end else begin
                state_r <= S_FREE;
              end
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_FREE: begin
          if (scan_r == SCNT_W'(SLOTS)) begin
            rep_status_r <= ST_FULL;
            rep_id_r     <= '0;
            state_r      <= S_REPLY;
          end else if (!valid_r[sidx]) begin
            free_r <= sidx;
            for (int d = 0; d < SFX_DIGITS; d++) bcd_r[d] <= 4'd0;
            try_r   <= '0;
            state_r <= S_BUILD;
          end else begin
            scan_r <= scan_r + SCNT_W'(1);
          end
        end
        S_BUILD: begin
          cand_r  <= cand_nxt;
          clen_r  <= clen_nxt;
          scan_r  <= '0;
          state_r <= S_READ;
        end
        S_READ: state_r <= S_CMP;
        S_CMP: begin
          state_r <= S_READ;
          scan_r  <= scan_r + SCNT_W'(1);
          unique case (cmd_r)
            CMD_REGISTER: begin
              if (hit) begin
                if (try_r == SCNT_W'(SLOTS)) begin
                  rep_status_r <= ST_FULL;
                  rep_id_r     <= '0;
                  state_r      <= S_REPLY;
                end else begin
                  try_r    <= try_r + SCNT_W'(1);
                  bcd_r[0] <= (bcd_r[0] == DEC_MAX) ? 4'd0 : bcd_r[0] + 4'd1;
                  if (bcd_r[0] == DEC_MAX) begin
                    bcd_r[1] <= (bcd_r[1] == DEC_MAX) ? 4'd0 : bcd_r[1] + 4'd1;
                    if (bcd_r[1] == DEC_MAX) bcd_r[2] <= bcd_r[2] + 4'd1;
                  end
                  state_r <= S_BUILD;
                end
              end else if (last_slot) begin
                state_r <= S_WRITE;
              end
            end
            CMD_LOOKUP: begin
              if (hit) begin
                rep_status_r <= ST_OK;
                rep_id_r     <= row_owner;
                state_r      <= S_REPLY;
              end else if (last_slot) begin
                rep_status_r <= ST_NOT_FOUND;
                rep_id_r     <= '0;
                state_r      <= S_REPLY;
              end
            end
            CMD_OWNER: begin
              if (hit) begin
                cand_r  <= row_name;
                clen_r  <= row_len;
                idx_r   <= '0;
                state_r <= S_STREAM;
              end else if (last_slot) begin
                rep_status_r <= ST_NOT_FOUND;
                rep_id_r     <= '0;
                state_r      <= S_REPLY;
              end
            end
            default: begin
              if (hit) valid_r[sidx] <= 1'b0;
              if (last_slot) begin
                rep_status_r <= ST_OK;
                rep_id_r     <= '0;
                state_r      <= S_REPLY;
              end
            end
          endcase
        end
        S_WRITE: begin
          valid_r[free_r] <= 1'b1;
          idx_r           <= '0;
          state_r         <= S_STREAM;
        end
        S_STREAM: begin
          if (can_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_id_r     <= '0;
            out_last_r   <= (idx_r == clen_r - LEN_W'(1));
            for (int i = 0; i < NAME_LIMIT; i++) begin
              if (int'(idx_r) == i) out_char_r <= cand_r[i*8 +: 8];
            end
            idx_r <= idx_r + LEN_W'(1);
            if (idx_r == clen_r - LEN_W'(1)) state_r <= S_IDLE;
          end
        end
        S_REPLY: begin
          if (can_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= rep_status_r;
            out_id_r     <= rep_id_r;
            out_char_r   <= 8'h00;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found_id = out_id_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;

endmodule

// File: sv/unrt_checker.sv
`timescale 1ns / 1ps
module unrt_checker import unrt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_id,
  input logic [7:0]  out_char,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_status))
    else $error("result changed while stalled");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_char == 8'h00 && out_found_id == '0)
    else $error("failure result malformed");

  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char != 8'h00 |-> out_status == ST_OK && out_found_id == '0)
    else $error("name byte with status or id");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind unique_name_registry_table_core unrt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_found_id(out_found_id), .out_char(out_char),
  .out_last(out_last)
);
